// ===== design/load_cell_adc_reader_tare_scale_top_assert.svh =====
// Assertion macros used by the reader's controller.
`ifndef LOAD_CELL_ADC_READER_TARE_SCALE_TOP_ASSERT_SVH
`define LOAD_CELL_ADC_READER_TARE_SCALE_TOP_ASSERT_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define LCR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge out of reset.
`define LCR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/lcr_pkg.sv =====
// Package: shared constants and controller/datapath interface types of the reader.
package lcr_pkg;

	localparam int SAMPLE_BITS_DEF = 24;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;
	localparam int DIV_W      = 16;
	localparam int LIMIT_W    = 24;
	localparam int WEIGHT_W   = 25;

	localparam logic [CFG_IDX_W-1:0] REG_SCALE_DIVISOR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TARE_LIMIT    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_LIMIT  = 2'd2;

	localparam logic [DIV_W-1:0]   SCALE_DIVISOR_RST = 16'd415;
	localparam logic [LIMIT_W-1:0] TARE_LIMIT_RST    = 24'd25000;
	localparam logic [LIMIT_W-1:0] WEIGHT_LIMIT_RST  = 24'd5000;

	localparam int TARE_ROUND = 50;

	localparam logic signed [WEIGHT_W-1:0] WEIGHT_MIN = 25'sh1000000;

	// controller -> datapath
	typedef struct packed {
		logic step;      // take one tick beat
		logic div_iter;  // one restoring-divide step
		logic finish;    // apply quotient to held weight
	} lcr_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic need_div;  // current tick completes a non-tare reading
	} lcr_sts_t;

endpackage

// ===== design/lcr_ctrl.sv =====
// Controller: tick handshake, divide sequencing and result handshake.
`include "load_cell_adc_reader_tare_scale_top_assert.svh"

module lcr_ctrl
	import lcr_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  lcr_sts_t sts,
	output lcr_cmd_t cmd
);

	localparam int QW   = SAMPLE_BITS + 1;
	localparam int CNTW = $clog2(QW);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_FIN  = 3'b100
	} lcr_state_t;

	lcr_state_t      state_q;
	logic [CNTW-1:0] iter_q;
	logic            out_valid_q;
	logic            accept;
	logic            set_out;

	assign in_ready  = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.step     = accept;
		cmd.div_iter = (state_q == ST_DIV);
		cmd.finish   = (state_q == ST_FIN);
		set_out      = (accept && !sts.need_div) || (state_q == ST_FIN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			iter_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (set_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && sts.need_div) begin
						state_q <= ST_DIV;
						iter_q  <= '0;
					end
				end
				ST_DIV: begin
					// one quotient bit per cycle
					if (iter_q == CNTW'(QW - 1)) begin
						state_q <= ST_FIN;
					end else begin
						iter_q <= iter_q + 1'b1;
					end
				end
				ST_FIN: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`LCR_ASSERT_NOW(a_no_accept_busy, state_q != ST_IDLE, !in_ready, "tick taken while dividing")
	`LCR_ASSERT_NEXT(a_div_starts, accept && sts.need_div,
		(state_q == ST_DIV) && !out_valid, "divide did not start cleanly")
	`LCR_ASSERT_NEXT(a_fin_shows, state_q == ST_FIN, out_valid, "finished reading not shown")
	`LCR_ASSERT_NEXT(a_tick_shows, accept && !sts.need_div, out_valid, "tick result not shown")

endmodule

// ===== design/lcr_dp.sv =====
// Datapath: serial sequencing, tare store, restoring divider and held weight.
module lcr_dp
	import lcr_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  lcr_cmd_t                   cmd,
	output lcr_sts_t                   sts,
	input  logic                       data_line,
	input  logic                       cfg_we,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data,
	output logic                       clock_line,
	output logic                       weight_valid,
	output logic                       tare_taken,
	output logic signed [WEIGHT_W-1:0] weight_grams
);

	localparam int PW = $clog2(SAMPLE_BITS + 2);
	localparam int QW = SAMPLE_BITS + 1;
	localparam int NW = SAMPLE_BITS + 2;
	localparam int RW = (SAMPLE_BITS > LIMIT_W) ? SAMPLE_BITS : LIMIT_W;
	localparam int CW = (NW > LIMIT_W + 2) ? NW : LIMIT_W + 2;

	logic [DIV_W-1:0]   scale_divisor_q;
	logic [LIMIT_W-1:0] tare_limit_q;
	logic [LIMIT_W-1:0] weight_limit_q;

	logic [PW-1:0]          phase_q;
	logic                   clock_level_q;
	logic [SAMPLE_BITS-1:0] raw_q;
	logic [SAMPLE_BITS-1:0] tare_q;
	logic                   tare_pending_q;
	logic signed [WEIGHT_W-1:0] held_q;
	logic                   weight_valid_q;
	logic                   tare_taken_q;

	logic [QW-1:0]    dvd_q;
	logic [DIV_W-1:0] rem_q;
	logic             neg_q;

	logic                 last_edge;
	logic                 take_tare;
	logic signed [NW-1:0] num;
	logic signed [NW-1:0] num_abs;
	logic [DIV_W-1:0]     divisor;
	logic [DIV_W:0]       trial;
	logic                 qbit;
	logic [DIV_W:0]       trial_diff;
	logic signed [NW-1:0] quo_s;
	logic signed [CW-1:0] quo_ext;
	logic signed [CW-1:0] limit_ext;
	logic signed [CW-1:0] wmin_ext;

	assign last_edge = (phase_q == PW'(SAMPLE_BITS + 1)) && clock_level_q;
	assign take_tare = tare_pending_q && (RW'(raw_q) < RW'(tare_limit_q));
	assign sts.need_div = last_edge && !take_tare;

	assign num     = $signed(NW'(raw_q)) - $signed(NW'(tare_q)) + NW'(TARE_ROUND);
	assign num_abs = num[NW-1] ? -num : num;
	assign divisor = (scale_divisor_q == '0) ? DIV_W'(1) : scale_divisor_q;

	assign trial      = {rem_q, dvd_q[QW-1]};
	assign qbit       = (trial >= {1'b0, divisor});
	assign trial_diff = trial - {1'b0, divisor};

	assign quo_s     = neg_q ? -$signed({1'b0, dvd_q}) : $signed({1'b0, dvd_q});
	assign quo_ext   = CW'(quo_s);
	assign limit_ext = $signed(CW'(weight_limit_q));
	assign wmin_ext  = CW'(WEIGHT_MIN);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_divisor_q <= SCALE_DIVISOR_RST;
			tare_limit_q    <= TARE_LIMIT_RST;
			weight_limit_q  <= WEIGHT_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SCALE_DIVISOR: scale_divisor_q <= cfg_data[DIV_W-1:0];
				REG_TARE_LIMIT:    tare_limit_q    <= cfg_data[LIMIT_W-1:0];
				REG_WEIGHT_LIMIT:  weight_limit_q  <= cfg_data[LIMIT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// serial sequencing, tare and held weight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= '0;
			clock_level_q  <= 1'b0;
			raw_q          <= '0;
			tare_q         <= '0;
			tare_pending_q <= 1'b1;
			held_q         <= '0;
			weight_valid_q <= 1'b0;
			tare_taken_q   <= 1'b0;
		end else if (cmd.step) begin
			weight_valid_q <= 1'b0;
			tare_taken_q   <= 1'b0;
			if (phase_q == '0) begin
				clock_level_q <= 1'b0;
				if (!data_line) begin
					raw_q         <= '0;
					clock_level_q <= 1'b1;
					phase_q       <= PW'(1);
				end
			end else if (clock_level_q) begin
				clock_level_q <= 1'b0;
				if (last_edge) begin
					phase_q <= '0;
					if (take_tare) begin
						tare_q         <= raw_q;
						tare_pending_q <= 1'b0;
						tare_taken_q   <= 1'b1;
					end
				end
			end else begin
				raw_q         <= {raw_q[SAMPLE_BITS-2:0], data_line};
				clock_level_q <= 1'b1;
				phase_q       <= phase_q + 1'b1;
			end
		end else if (cmd.finish) begin
			// drop weights at or above the limit, clamp the low end
			if (quo_ext < limit_ext) begin
				held_q         <= (quo_ext < wmin_ext) ? WEIGHT_MIN : quo_ext[WEIGHT_W-1:0];
				weight_valid_q <= 1'b1;
			end
		end
	end

	// restoring divider on the magnitude
	always_ff @(posedge clk) begin
		if (cmd.step && sts.need_div) begin
			dvd_q <= num_abs[QW-1:0];
			rem_q <= '0;
			neg_q <= num[NW-1];
		end else if (cmd.div_iter) begin
			rem_q <= qbit ? trial_diff[DIV_W-1:0] : trial[DIV_W-1:0];
			dvd_q <= {dvd_q[QW-2:0], qbit};
		end
	end

	assign clock_line   = clock_level_q;
	assign weight_valid = weight_valid_q;
	assign tare_taken   = tare_taken_q;
	assign weight_grams = held_q;

endmodule

// ===== design/load_cell_adc_reader_tare_scale_top.sv =====
// Top level of the load-cell serial converter reader with tare and scaling.
// One beat on the input channel is one half period of the converter's serial
// clock and gives one result beat: the clock level to drive, the two event
// flags and the held weight. An ordinary tick's result is shown in the cycle
// after the tick is taken. The tick on which the last pulse falls and the
// reading is not taken as tare runs through the tick itself, the restoring
// divider that yields one quotient bit per cycle, and a final step that
// applies the limit and, below it, updates the weight. The next tick is
// taken in the cycle that the pending result leaves. Configuration writes are
// taken in any cycle; an index beyond the register list is ignored.
module load_cell_adc_reader_tare_scale_top
	import lcr_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       data_line,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       clock_line,
	output logic                       weight_valid,
	output logic                       tare_taken,
	output logic signed [WEIGHT_W-1:0] weight_grams,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data
);

	lcr_cmd_t cmd;
	lcr_sts_t sts;

	assign cfg_ready = 1'b1;

	lcr_ctrl #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lcr_dp #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.data_line   (data_line),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.clock_line  (clock_line),
		.weight_valid(weight_valid),
		.tare_taken  (tare_taken),
		.weight_grams(weight_grams)
	);

endmodule
